// ===== rtl/core/chs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants of the chained hash set.
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam int BUCKETS    = 256;
    localparam int POOL_NODES = 512;
    localparam int KEY_BITS   = 32;

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int IDX_W = $clog2(POOL_NODES);
    localparam int PTR_W = IDX_W + 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int BC_W  = 9;
    localparam int DIV_W = $clog2(KEY_BITS);

    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

    typedef enum logic [1:0] {
        CMD_CONTAINS = 2'd0,
        CMD_INSERT   = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RES_ABSENT  = 2'd0,
        RES_PRESENT = 2'd1,
        RES_NEW     = 2'd2,
        RES_FULL    = 2'd3
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_HEAD,
        ST_HLAT,
        ST_CHK,
        ST_CMP,
        ST_ACT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic start;
        logic div_step;
        logic head_load;
        logic node_adv;
        logic found_set;
        logic commit;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic div_last;
        logic node_nil;
        logic key_match;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/chs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chs_ctrl
// Sequencer: divide, fetch bucket head, walk chain, commit, hand off result.
// ----------------------------------------------------------------------------
module chs_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  chs_pkg::stat_t      stat,
    output chs_pkg::ctrl_t      ctrl
);
    import chs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_DIV;
            ST_DIV:  if (stat.div_last) state_next = ST_HEAD;
            ST_HEAD: state_next = ST_HLAT;
            ST_HLAT: state_next = ST_CHK;
            ST_CHK:  state_next = stat.node_nil ? ST_ACT : ST_CMP;
            ST_CMP:  state_next = stat.key_match ? ST_ACT : ST_CHK;
            ST_ACT:  state_next = ST_FIN;
            ST_FIN:  if (stat.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl    = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                ctrl.start = s_valid;
            end
            ST_DIV:  ctrl.div_step  = 1'b1;
            ST_HLAT: ctrl.head_load = 1'b1;
            ST_CMP: begin
                ctrl.found_set = stat.key_match;
                ctrl.node_adv  = !stat.key_match;
            end
            ST_ACT:  ctrl.commit   = 1'b1;
            ST_FIN:  ctrl.out_load = stat.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/chs_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chs_dp
// Datapath: bucket divider, head/node/free-stack memories, result register.
// ----------------------------------------------------------------------------
module chs_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [1:0]                   s_command,
    input  wire logic [chs_pkg::KEY_BITS-1:0] s_key,
    input  wire logic                         cfg_valid,
    input  wire logic [chs_pkg::BC_W-1:0]     cfg_data,
    input  wire logic                         m_ready,
    output logic                              m_valid,
    output logic [1:0]                        m_result_code,
    input  chs_pkg::ctrl_t                    ctrl,
    output chs_pkg::stat_t                    stat
);
    import chs_pkg::*;

    logic [BC_W-1:0]     bc_reg;
    logic [BC_W-1:0]     divisor;
    logic [1:0]          cmd_reg;
    logic [KEY_BITS-1:0] key_reg, shk_reg;
    logic [BC_W-1:0]     rem_reg;
    logic [BC_W:0]       trial;
    logic [DIV_W-1:0]    dcnt_reg;
    logic [PTR_W-1:0]    node_reg, prev_reg, next_reg, head_reg;
    logic                found_reg;
    logic [CNT_W-1:0]    count_reg, low_reg;
    logic                m_valid_reg;
    logic [1:0]          code_reg, m_code_reg;
    logic [BKT_W-1:0]    bkt;

    logic [PTR_W-1:0]    hd_mem [BUCKETS];
    logic [KEY_BITS-1:0] nk_mem [POOL_NODES];
    logic [PTR_W-1:0]    nn_mem [POOL_NODES];
    logic [IDX_W-1:0]    fs_mem [POOL_NODES];
    logic [BUCKETS-1:0]  hv_reg;

    logic [PTR_W-1:0]    hd_rd, nn_rd;
    logic [KEY_BITS-1:0] nk_rd;
    logic [IDX_W-1:0]    fs_rd;
    logic                hv_rd;

    logic                hd_we, nk_we, nn_we, fs_we;
    logic [PTR_W-1:0]    hd_wd, nn_wd;
    logic [IDX_W-1:0]    nk_wa, nn_wa, fs_wa, fs_wd, alloc;

    assign bkt     = rem_reg[BKT_W-1:0];
    assign divisor = (bc_reg == '0) ? BC_W'(1) :
                     (bc_reg > BC_W'(BUCKETS)) ? BC_W'(BUCKETS) : bc_reg;
    assign trial   = {rem_reg, shk_reg[KEY_BITS-1]};
    assign alloc   = (count_reg == low_reg) ? IDX_W'(CNT_W'(POOL_NODES) - count_reg)
                                            : fs_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg <= BC_W'(256);
        end else if (cfg_valid) begin
            bc_reg <= cfg_data;
        end
    end

    // memory reads, registered
    always_ff @(posedge aclk) begin
        hd_rd <= hd_mem[bkt];
        hv_rd <= hv_reg[bkt];
        nk_rd <= nk_mem[node_reg[IDX_W-1:0]];
        nn_rd <= nn_mem[node_reg[IDX_W-1:0]];
        fs_rd <= fs_mem[IDX_W'(count_reg - CNT_W'(1))];
    end

    always_ff @(posedge aclk) begin
        if (hd_we) hd_mem[bkt] <= hd_wd;
        if (nk_we) nk_mem[nk_wa] <= key_reg;
        if (nn_we) nn_mem[nn_wa] <= nn_wd;
        if (fs_we) fs_mem[fs_wa] <= fs_wd;
    end

    always_comb begin
        hd_we = 1'b0; hd_wd = head_reg;
        nk_we = 1'b0; nk_wa = alloc;
        nn_we = 1'b0; nn_wa = alloc; nn_wd = head_reg;
        fs_we = 1'b0; fs_wa = count_reg[IDX_W-1:0]; fs_wd = node_reg[IDX_W-1:0];
        if (ctrl.commit) begin
            if (found_reg && cmd_reg == CMD_REMOVE) begin
                if (prev_reg == NIL) begin
                    hd_we = 1'b1;
                    hd_wd = next_reg;
                end else begin
                    nn_we = 1'b1;
                    nn_wa = prev_reg[IDX_W-1:0];
                    nn_wd = next_reg;
                end
                fs_we = (count_reg < CNT_W'(POOL_NODES));
            end else if (!found_reg && cmd_reg == CMD_INSERT && count_reg != '0) begin
                hd_we = 1'b1;
                hd_wd = {1'b0, alloc};
                nk_we = 1'b1;
                nn_we = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hv_reg <= '0;
        end else if (hd_we) begin
            hv_reg[bkt] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= CNT_W'(POOL_NODES);
            low_reg     <= CNT_W'(POOL_NODES);
            m_valid_reg <= 1'b0;
        end else begin
            if (fs_we) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (nk_we) begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == low_reg) low_reg <= count_reg - CNT_W'(1);
            end
            if (ctrl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            cmd_reg   <= s_command;
            key_reg   <= s_key;
            shk_reg   <= s_key;
            rem_reg   <= '0;
            dcnt_reg  <= '0;
            found_reg <= 1'b0;
        end
        if (ctrl.div_step) begin
            rem_reg  <= (trial >= {1'b0, divisor}) ? BC_W'(trial - {1'b0, divisor})
                                                   : BC_W'(trial);
            shk_reg  <= shk_reg << 1;
            dcnt_reg <= dcnt_reg + DIV_W'(1);
        end
        if (ctrl.head_load) begin
            node_reg <= hv_rd ? hd_rd : NIL;
            head_reg <= hv_rd ? hd_rd : NIL;
            prev_reg <= NIL;
        end
        if (ctrl.node_adv) begin
            prev_reg <= node_reg;
            node_reg <= nn_rd;
        end
        if (ctrl.found_set) begin
            found_reg <= 1'b1;
            next_reg  <= nn_rd;
        end
        if (ctrl.commit) begin
            if (found_reg) begin
                code_reg <= (cmd_reg == CMD_NONE) ? RES_ABSENT : RES_PRESENT;
            end else if (cmd_reg == CMD_INSERT) begin
                code_reg <= (count_reg == '0) ? RES_FULL : RES_NEW;
            end else begin
                code_reg <= RES_ABSENT;
            end
        end
        if (ctrl.out_load) m_code_reg <= code_reg;
    end

    assign stat.div_last  = (dcnt_reg == DIV_W'(KEY_BITS - 1));
    assign stat.node_nil  = (node_reg >= NIL);
    assign stat.key_match = (nk_rd == key_reg);
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_result_code = m_code_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(POOL_NODES)) else $error("free count out of range");
    a_low_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        low_reg <= count_reg) else $error("low mark above free count");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.head_load |-> rem_reg < divisor) else $error("remainder not reduced");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/chained_hash_set.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_set
// Hash set of 32-bit keys, separate chaining over a 512-node pool.
// ----------------------------------------------------------------------------
// One command at a time. From one accepted transfer to the next, a command passes
// through the idle state, bit-serial key mod bucket_count, the registered bucket
// head read, a node memory read and key compare per chain node, a final
// end-of-chain check when nothing matched, a commit step and the load of the
// result register. That load is held while an earlier result still waits for
// m_ready. No clearing pass after reset; bucket_count may be written at any
// time the block is idle.
module chained_hash_set (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [1:0]                   s_command,
    input  wire logic [chs_pkg::KEY_BITS-1:0] s_key,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [1:0]                        m_result_code,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [chs_pkg::BC_W-1:0]     cfg_data
);
    import chs_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    assign cfg_ready = 1'b1;

    chs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    chs_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_command     (s_command),
        .s_key         (s_key),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_result_code (m_result_code),
        .ctrl          (ctrl),
        .stat          (stat)
    );

endmodule
`default_nettype wire

// ===== verif/chained_hash_set_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_set_test
// Self-checking bench for the chained hash set. A directed table and a pool
// fill are followed by random command streams over mostly small key spaces,
// each result checked against the table or a behavioural copy of the set.
// ----------------------------------------------------------------------------
module chained_hash_set_test;
    import chs_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = CMD_CONTAINS;
    logic [31:0] s_key = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_result_code;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;

    chained_hash_set uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command), .s_key(s_key),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_code(m_result_code),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // model state
    logic [9:0]  mdl_head [BUCKETS];
    logic [31:0] mdl_key  [POOL_NODES];
    logic [9:0]  mdl_next [POOL_NODES];
    logic [9:0]  mdl_free [POOL_NODES];
    int          mdl_free_cnt;
    logic [8:0]  mdl_bc;

    logic [1:0]  code_fifo [$];
    int          errors = 0;
    int          send_idle = 9, recv_idle = 81;

    function automatic logic [1:0] set_apply(logic [1:0] cmd, logic [31:0] key);
        int d, b, node, prev, steps;
        bit found;
        logic [1:0] code;
        d = mdl_bc;
        if (d == 0) d = 1;
        if (d > BUCKETS) d = BUCKETS;
        b = key % d;
        node = mdl_head[b];
        prev = POOL_NODES;
        steps = 0;
        found = 0;
        code = RES_ABSENT;
        while (node < POOL_NODES && steps < POOL_NODES) begin
            if (mdl_key[node] == key) begin
                found = 1;
                break;
            end
            prev = node;
            node = mdl_next[node];
            steps++;
        end
        case (cmd)
            CMD_CONTAINS: code = found ? RES_PRESENT : RES_ABSENT;
            CMD_INSERT: begin
                if (found) code = RES_PRESENT;
                else if (mdl_free_cnt == 0) code = RES_FULL;
                else begin
                    mdl_free_cnt--;
                    node = mdl_free[mdl_free_cnt];
                    mdl_key[node] = key;
                    mdl_next[node] = mdl_head[b];
                    mdl_head[b] = 10'(node);
                    code = RES_NEW;
                end
            end
            CMD_REMOVE: begin
                if (found) begin
                    if (prev >= POOL_NODES) mdl_head[b] = mdl_next[node];
                    else mdl_next[prev] = mdl_next[node];
                    mdl_next[node] = 10'(POOL_NODES);
                    mdl_free[mdl_free_cnt] = 10'(node);
                    mdl_free_cnt++;
                    code = RES_PRESENT;
                end
            end
            default: code = RES_ABSENT;
        endcase
        return code;
    endfunction

    task automatic send_cmd(logic [1:0] cmd, logic [31:0] key, int exp_code);
        logic [1:0] code;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        code = set_apply(cmd, key);
        if (exp_code >= 0 && code != exp_code[1:0]) begin
            $display("%0t table row disagrees: expected %0d model %0d", $time, exp_code, code);
            errors++;
        end
        code_fifo.push_back(exp_code >= 0 ? exp_code[1:0] : code);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_key     <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_bc(logic [8:0] val);
        s_valid <= 1'b0;
        while (code_fifo.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        mdl_bc = val;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (code_fifo.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %0d",
                             $time, m_result_code);
                    errors++;
                end else begin
                    if (m_result_code !== code_fifo[0]) begin
                        $display("%0t result_code mismatch: expected %0d actual %0d",
                                 $time, code_fifo[0], m_result_code);
                        errors++;
                    end
                    void'(code_fifo.pop_front());
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] key;
        int          exp_code;
    } row_t;

    row_t dir_tbl [] = '{
        '{CMD_CONTAINS, 32'h0,        RES_ABSENT},
        '{CMD_REMOVE,   32'hFFFF_FFFF, RES_ABSENT},
        '{CMD_INSERT,   32'h0,        RES_NEW},
        '{CMD_INSERT,   32'h0,        RES_PRESENT},
        '{CMD_CONTAINS, 32'h0,        RES_PRESENT},
        '{CMD_INSERT,   32'hFFFF_FFFF, RES_NEW},
        '{CMD_INSERT,   32'h100,      RES_NEW},
        '{CMD_INSERT,   32'h200,      RES_NEW},
        '{CMD_REMOVE,   32'h200,      RES_PRESENT},
        '{CMD_REMOVE,   32'h0,        RES_PRESENT},
        '{CMD_CONTAINS, 32'h100,      RES_PRESENT},
        '{CMD_NONE,     32'h100,      RES_ABSENT},
        '{CMD_CONTAINS, 32'hAAAA_5555, RES_ABSENT},
        '{CMD_REMOVE,   32'h100,      RES_PRESENT},
        '{CMD_CONTAINS, 32'hFFFF_FFFF, RES_PRESENT}
    };

    function automatic logic [31:0] rand_key(int space);
        if ($urandom_range(19) == 0) return $urandom();
        if ($urandom_range(9) == 0) return 32'hFFFF_FFFF - $urandom_range(space);
        return $urandom_range(space);
    endfunction

    initial begin
        logic [8:0] bc_list [] = '{9'd1, 9'd0, 9'd511, 9'd257, 9'd7, 9'd256};
        int per;
        for (int i = 0; i < BUCKETS; i++) mdl_head[i] = 10'(POOL_NODES);
        for (int i = 0; i < POOL_NODES; i++) begin
            mdl_next[i] = 10'(POOL_NODES);
            mdl_key[i]  = '0;
            mdl_free[i] = 10'(POOL_NODES - 1 - i);
        end
        mdl_free_cnt = POOL_NODES;
        mdl_bc = 9'd256;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tbl[i]) send_cmd(dir_tbl[i].cmd, dir_tbl[i].key, dir_tbl[i].exp_code);

        // fill the pool with few buckets to reach full, then drain part of it
        write_bc(9'd3);
        for (int i = 0; i < 513; i++) send_cmd(CMD_INSERT, i, -1);
        for (int i = 0; i < 260; i++) send_cmd(CMD_REMOVE, i, -1);

        per = 44;
        foreach (bc_list[p]) begin
            write_bc(bc_list[p]);
            if (p == 2) begin send_idle = 81; recv_idle = 9; end
            if (p == 4) begin send_idle = 0;  recv_idle = 0; end
            for (int i = 0; i < per; i++)
                send_cmd($urandom_range(99) < 3 ? CMD_NONE : 2'($urandom_range(2)),
                         rand_key(p == 0 ? 15 : 60), -1);
        end

        s_valid <= 1'b0;
        while (code_fifo.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) $display("chained_hash_set verification clean");
        else $display("chained_hash_set verification failed");
        $finish;
    end

    initial begin
        #100ms;
        $display("chained_hash_set verification failed");
        $finish;
    end
endmodule
